>>> design/bsmg_pkg.sv
`timescale 1ns / 1ps

package bsmg_pkg;

    localparam int CNT_W = 11;
    localparam int VAL_W = 32;

    localparam logic [VAL_W-1:0] SIGN_BIAS = 32'h8000_0000;
    localparam logic [VAL_W-1:0] GAP_RESET = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    // Status codes of a result
    localparam logic ST_STORED = 1'b0;
    localparam logic ST_FULL   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } bsmg_state_t;

    typedef struct packed {
        logic             status;
        logic [CNT_W-1:0] count;
        logic             span_valid;
        logic [VAL_W-1:0] shortest;
        logic [VAL_W-1:0] longest;
    } bsmg_result_t;

endpackage

>>> design/bsmg_store.sv
`timescale 1ns / 1ps

module bsmg_store #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [bsmg_pkg::VAL_W-1:0]    wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [bsmg_pkg::VAL_W-1:0]    rdata
);

    logic [bsmg_pkg::VAL_W-1:0] mem [DEPTH];
    logic [bsmg_pkg::VAL_W-1:0] rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/bsmg_scan.sv
`timescale 1ns / 1ps

module bsmg_scan #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [bsmg_pkg::VAL_W-1:0]  new_value,
    input  logic [bsmg_pkg::CNT_W-1:0]         capacity,
    output logic                               busy,
    output logic                               full,
    output logic                               finish,
    output bsmg_pkg::bsmg_result_t             result,
    output logic                               mem_we,
    output logic [$clog2(DEPTH)-1:0]           mem_waddr,
    output logic [bsmg_pkg::VAL_W-1:0]         mem_wdata,
    output logic                               mem_re,
    output logic [$clog2(DEPTH)-1:0]           mem_raddr,
    input  logic [bsmg_pkg::VAL_W-1:0]         mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = bsmg_pkg::CNT_W;
    localparam int VW = bsmg_pkg::VAL_W;

    bsmg_pkg::bsmg_state_t state_reg, state_next;

    logic [CW-1:0] count_reg;
    logic [VW-1:0] min_reg;
    logic [VW-1:0] max_reg;
    logic [VW-1:0] gap_reg;
    logic [VW-1:0] val_reg;
    logic [CW-1:0] idx_reg;
    logic          rd_vld_reg;
    logic [VW-1:0] diff_reg, diff_next;
    logic          diff_vld_reg;

    logic          accept;
    logic          issue;
    logic          scan_done;
    logic [CW-1:0] count_inc;
    logic [VW-1:0] min_new;
    logic [VW-1:0] max_new;
    logic [AW+CW-1:0] raddr_wide;
    logic [AW+CW-1:0] waddr_wide;

    assign accept    = start && (state_reg == bsmg_pkg::S_IDLE);
    assign full      = (32'(count_reg) >= 32'(capacity)) || (32'(count_reg) >= 32'(DEPTH));
    assign issue     = (state_reg == bsmg_pkg::S_SCAN) && (idx_reg != count_reg);
    assign scan_done = !issue && !rd_vld_reg && !diff_vld_reg;
    assign count_inc = count_reg + 1'b1;
    assign busy      = (state_reg != bsmg_pkg::S_IDLE);

    // Map counters onto store addresses
    assign raddr_wide = {{AW{1'b0}}, idx_reg};
    assign waddr_wide = {{AW{1'b0}}, count_reg};
    assign mem_raddr  = raddr_wide[AW-1:0];
    assign mem_waddr  = waddr_wide[AW-1:0];
    assign mem_wdata  = val_reg;

    // Absolute gap between the new value and the entry just read
    assign diff_next = (val_reg >= mem_rdata) ? (val_reg - mem_rdata) : (mem_rdata - val_reg);

    // Extremes after the new value joins
    always_comb
    begin
        if (count_reg == '0)
        begin
            min_new = val_reg;
            max_new = val_reg;
        end
        else
        begin
            min_new = (val_reg < min_reg) ? val_reg : min_reg;
            max_new = (val_reg > max_reg) ? val_reg : max_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bsmg_pkg::S_IDLE:
            begin
                if (accept && !full)
                begin
                    state_next = bsmg_pkg::S_SCAN;
                end
            end
            bsmg_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = bsmg_pkg::S_COMMIT;
                end
            end
            bsmg_pkg::S_COMMIT:
            begin
                state_next = bsmg_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bsmg_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs per state
    always_comb
    begin
        mem_re            = 1'b0;
        mem_we            = 1'b0;
        finish            = 1'b0;
        result.status     = bsmg_pkg::ST_FULL;
        result.count      = count_reg;
        result.span_valid = (count_reg >= CW'(2));
        result.shortest   = result.span_valid ? gap_reg : '0;
        result.longest    = result.span_valid ? (max_reg - min_reg) : '0;
        unique case (state_reg)
            bsmg_pkg::S_IDLE:
            begin
                finish = accept && full;
            end
            bsmg_pkg::S_SCAN:
            begin
                mem_re = issue;
            end
            bsmg_pkg::S_COMMIT:
            begin
                mem_we            = 1'b1;
                finish            = 1'b1;
                result.status     = bsmg_pkg::ST_STORED;
                result.count      = count_inc;
                result.span_valid = (count_inc >= CW'(2));
                result.shortest   = result.span_valid ? gap_reg : '0;
                result.longest    = result.span_valid ? (max_new - min_new) : '0;
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    // Control and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bsmg_pkg::S_IDLE;
            count_reg    <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            gap_reg      <= bsmg_pkg::GAP_RESET;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            diff_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            diff_vld_reg <= rd_vld_reg;
            if (accept && !full)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            // Keep the smallest gap seen
            if (diff_vld_reg && (diff_reg < gap_reg))
            begin
                gap_reg <= diff_reg;
            end
            if (state_reg == bsmg_pkg::S_COMMIT)
            begin
                count_reg <= count_inc;
                min_reg   <= min_new;
                max_reg   <= max_new;
            end
        end
    end

    // Payload: latch the offset-binary value and the gap pipeline
    always_ff @(posedge clk)
    begin
        if (accept && !full)
        begin
            val_reg <= new_value ^ bsmg_pkg::SIGN_BIAS;
        end
        diff_reg <= diff_next;
    end

endmodule

>>> design/bounded_set_min_gap_and_range.sv
`timescale 1ns / 1ps
// For a rejected transaction done is high in the first cycle after the accepting edge;
// a stored one passes through S_SCAN, where each held value costs one read of the value
// store, then through S_COMMIT and the registered done. Rejected transactions are taken
// one per cycle; a stored one keeps busy high, so no new value is taken until it commits.
// The receiver cannot stall results.
// Reset: capacity returns to 1024, count, minimum and maximum clear, shortest gap goes to
// all ones; the value store is not cleared and needs no clearing pass.

module bounded_set_min_gap_and_range #(
    parameter int unsigned STORE_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [bsmg_pkg::VAL_W-1:0]  new_value,
    input  logic                               capacity_we,
    input  logic [bsmg_pkg::CNT_W-1:0]         capacity_wdata,
    output logic                               done,
    output logic                               status,
    output logic [bsmg_pkg::CNT_W-1:0]         stored_count,
    output logic                               span_valid,
    output logic [bsmg_pkg::VAL_W-1:0]         min_span,
    output logic [bsmg_pkg::VAL_W-1:0]         longest_span
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [bsmg_pkg::CNT_W-1:0] capacity_reg;
    logic                       done_reg;
    bsmg_pkg::bsmg_result_t     result_reg;

    bsmg_pkg::bsmg_result_t     result;
    logic                       finish;
    logic                       full;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [bsmg_pkg::VAL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [bsmg_pkg::VAL_W-1:0] mem_rdata;

    // Hold the capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bsmg_pkg::CAP_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= finish;
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
        end
    end

    // Register the result transaction
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            result_reg <= result;
        end
    end

    bsmg_scan #(
        .DEPTH (STORE_DEPTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .new_value (new_value),
        .capacity  (capacity_reg),
        .busy      (busy),
        .full      (full),
        .finish    (finish),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bsmg_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign done          = done_reg;
    assign status        = result_reg.status;
    assign stored_count  = result_reg.count;
    assign span_valid    = result_reg.span_valid;
    assign min_span      = result_reg.shortest;
    assign longest_span  = result_reg.longest;

    // A transaction offered to a full store is answered in the next cycle
    a_reject_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && full) |=> (done && status == bsmg_pkg::ST_FULL))
        else $error("rejected transaction not answered in the next cycle");

    // The shortest gap can never exceed the range
    a_gap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && span_valid) |-> (min_span <= longest_span))
        else $error("shortest span exceeds longest span");

    // A result leaves the block idle and ready for the next transaction
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    // A stored value never leaves the count at zero
    a_stored_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bsmg_pkg::ST_STORED) |-> (stored_count != '0))
        else $error("stored transaction reports an empty set");

endmodule

>>> verif/bsmg_span_checker.sv
`timescale 1ns / 1ps

module bsmg_span_checker #(
    parameter int unsigned STORE_DEPTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic signed [bsmg_pkg::VAL_W-1:0] new_value,
    input  logic                              capacity_we,
    input  logic [bsmg_pkg::CNT_W-1:0]        capacity_wdata,
    input  logic                              done,
    input  logic                              status,
    input  logic [bsmg_pkg::CNT_W-1:0]        stored_count,
    input  logic                              span_valid,
    input  logic [bsmg_pkg::VAL_W-1:0]        min_span,
    input  logic [bsmg_pkg::VAL_W-1:0]        longest_span,
    output int unsigned                       fail_count,
    output int unsigned                       pending,
    output int unsigned                       held
);

    localparam int VW = bsmg_pkg::VAL_W;
    localparam int CW = bsmg_pkg::CNT_W;

    // Shadow copy of the set: values kept offset-binary so unsigned order is signed order
    logic [CW-1:0] cap_shadow;
    logic [VW-1:0] set_vals [STORE_DEPTH];
    int unsigned   set_size;
    logic [VW-1:0] set_lo;
    logic [VW-1:0] set_hi;
    logic [VW-1:0] set_gap;

    // Results still owed by the block, oldest first
    bsmg_pkg::bsmg_result_t awaited_spans [$];

    // Add one value to the shadow set unless it is full, and return the result it must produce
    function automatic bsmg_pkg::bsmg_result_t predict_add(input logic [VW-1:0] raw);
        int unsigned            eff_cap;
        logic [VW-1:0]          v;
        logic [VW-1:0]          d;
        bsmg_pkg::bsmg_result_t r;
        eff_cap = (cap_shadow > STORE_DEPTH) ? STORE_DEPTH : int'(cap_shadow);
        r.status = bsmg_pkg::ST_STORED;
        if (set_size >= eff_cap)
        begin
            r.status = bsmg_pkg::ST_FULL;
        end
        else
        begin
            v = raw ^ bsmg_pkg::SIGN_BIAS;
            for (int i = 0; i < set_size; i++)
            begin
                d = (v >= set_vals[i]) ? v - set_vals[i] : set_vals[i] - v;
                if (d < set_gap)
                    set_gap = d;
            end
            if (set_size == 0)
            begin
                set_lo = v;
                set_hi = v;
            end
            else
            begin
                if (v < set_lo)
                    set_lo = v;
                if (v > set_hi)
                    set_hi = v;
            end
            set_vals[set_size] = v;
            set_size++;
        end
        r.count      = set_size[CW-1:0];
        r.span_valid = (set_size >= 2);
        r.shortest   = r.span_valid ? set_gap : '0;
        r.longest    = r.span_valid ? (set_hi - set_lo) : '0;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [VW-1:0] exp_v,
                                        input logic [VW-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected 0x%08h actual 0x%08h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // Retire results, track the capacity register, predict accepted transactions
    always @(posedge clk)
    begin
        bsmg_pkg::bsmg_result_t exp_r;
        if (!rst_n)
        begin
            cap_shadow = bsmg_pkg::CAP_RESET;
            set_size   = 0;
            set_lo     = '0;
            set_hi     = '0;
            set_gap    = bsmg_pkg::GAP_RESET;
            fail_count = 0;
            awaited_spans.delete();
        end
        else
        begin
            if (done)
            begin
                if (awaited_spans.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_r = awaited_spans.pop_front();
                    check_field("status", VW'(exp_r.status), VW'(status));
                    check_field("stored_count", VW'(exp_r.count), VW'(stored_count));
                    check_field("span_valid", VW'(exp_r.span_valid), VW'(span_valid));
                    check_field("min_span", exp_r.shortest, min_span);
                    check_field("longest_span", exp_r.longest, longest_span);
                end
            end
            if (capacity_we)
                cap_shadow = capacity_wdata;
            if (start && !busy)
                awaited_spans.insert(awaited_spans.size(), predict_add(new_value));
        end
        pending = awaited_spans.size();
        held    = set_size;
    end

endmodule

>>> verif/tb_bounded_set_min_gap_and_range.sv
`timescale 1ns / 1ps

module tb_bounded_set_min_gap_and_range;

    localparam int VW = bsmg_pkg::VAL_W;
    localparam int CW = bsmg_pkg::CNT_W;

    localparam int unsigned DEPTH        = 1024;
    localparam int unsigned RANDOM_ITEMS = 565;
    localparam int unsigned QUIET_TAIL   = 60;
    localparam logic [CW-1:0] CAP_MAX    = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [VW-1:0] new_value;
    logic                 capacity_we;
    logic [CW-1:0]        capacity_wdata;
    logic                 done;
    logic                 status;
    logic [CW-1:0]        stored_count;
    logic                 span_valid;
    logic [VW-1:0]        min_span;
    logic [VW-1:0]        longest_span;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned held;

    bit            gaps_on;
    logic [VW-1:0] offered [$];

    bounded_set_min_gap_and_range #(
        .STORE_DEPTH (DEPTH)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .new_value      (new_value),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .done           (done),
        .status         (status),
        .stored_count   (stored_count),
        .span_valid     (span_valid),
        .min_span       (min_span),
        .longest_span   (longest_span)
    );

    bsmg_span_checker #(
        .STORE_DEPTH (DEPTH)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .new_value      (new_value),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .done           (done),
        .status         (status),
        .stored_count   (stored_count),
        .span_valid     (span_valid),
        .min_span       (min_span),
        .longest_span   (longest_span),
        .fail_count     (fail_count),
        .pending        (pending),
        .held           (held)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb_bounded_set_min_gap_and_range NOT OK");
        $finish;
    end

    // Hold start until the block takes the transaction, then insert an optional gap
    task automatic offer_value(input logic [VW-1:0] v);
        int unsigned gap;
        start     <= 1'b1;
        new_value <= v;
        do
            @(posedge clk);
        while (busy);
        offered.insert(offered.size(), v);
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 11) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start and wait until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CW-1:0] cap);
        drain_results();
        capacity_we    <= 1'b1;
        capacity_wdata <= cap;
        @(posedge clk);
        capacity_we    <= 1'b0;
    endtask

    // Mix extremes, near neighbors, duplicates and fully random values
    function automatic logic [VW-1:0] pick_value();
        logic [VW-1:0] last_v;
        int unsigned   kind;
        kind   = $urandom_range(0, 9);
        last_v = (offered.size() != 0) ? offered[offered.size()-1] : '0;
        unique case (kind)
            0:
            begin
                unique case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2: return last_v + VW'($urandom_range(0, 8)) - VW'(4);
            3:
            begin
                if (offered.size() != 0)
                    return offered[$urandom_range(0, offered.size() - 1)];
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int unsigned   sent;
        int unsigned   phase_len;
        int unsigned   cap_pick;
        logic [CW-1:0] cap;

        rst_n          <= 1'b0;
        start          <= 1'b0;
        new_value      <= '0;
        capacity_we    <= 1'b0;
        capacity_wdata <= '0;
        gaps_on        = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset capacity, zero capacity, count at capacity, clamp above depth
        offer_value(32'h8000_0000);
        write_capacity('0);
        offer_value(32'd5);
        write_capacity(CW'(1));
        offer_value(32'd7);
        write_capacity(CAP_MAX);
        offer_value(32'h7FFF_FFFF);
        offer_value(32'h0000_0000);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'h0000_0001);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'h7FFF_FFFE);
        offer_value(32'h8000_0001);
        offer_value(32'h5555_5555);
        offer_value(32'hAAAA_AAAA);
        write_capacity(bsmg_pkg::CAP_RESET);
        offer_value(32'h1234_5678);
        offer_value(32'hEDCB_A987);
        drain_results();
        write_capacity(CW'(held));
        offer_value(32'h0000_0100);
        write_capacity(CW'(1));
        offer_value(32'h0000_0200);
        write_capacity(CW'(held + 3));
        offer_value(32'h0000_0300);
        offer_value(32'h0000_0301);
        offer_value(32'h0000_0302);
        offer_value(32'h0000_0303);

        // Random phases, each before the tail with its own capacity setting; the tail runs without idling
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent < RANDOM_ITEMS - QUIET_TAIL)
            begin
                drain_results();
                cap_pick = $urandom_range(0, 9);
                unique case (cap_pick)
                    0: cap = '0;
                    1: cap = CW'($urandom_range(0, held));
                    2: cap = CAP_MAX;
                    3: cap = bsmg_pkg::CAP_RESET;
                    4: cap = CW'($urandom_range(DEPTH, 2047));
                    default: cap = CW'(held + $urandom_range(1, 25));
                endcase
                write_capacity(cap);
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            phase_len = $urandom_range(4, 30);
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++)
            begin
                if (sent >= RANDOM_ITEMS - QUIET_TAIL)
                    gaps_on = 1'b0;
                else if ($urandom_range(0, 19) == 0)
                    drain_results();
                offer_value(pick_value());
                sent++;
            end
        end

        // Let the last results arrive, then leave a margin before the verdict
        drain_results();
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("tb_bounded_set_min_gap_and_range OK");
        else
            $display("tb_bounded_set_min_gap_and_range NOT OK");
        $finish;
    end

endmodule
